// ----- src/lls_pkg.sv -----
// Package for the bounded LIFO stack: sizes, action and status codes,
// and the control bundle that the top level hands to the row of cells.
// No dependencies.
`timescale 1ns / 1ps

package lls_pkg;

    localparam int DEPTH     = 128;
    localparam int POS_W     = $clog2(DEPTH);
    localparam int LVL_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = 7;
    localparam int COUNT_W   = 8;
    localparam int DATA_W    = 32;
    localparam int CMP_W     = (LVL_W > IDX_W) ? LVL_W : IDX_W;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_CHANGE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic                     change;
        logic [POS_W-1:0]         change_pos;
        logic signed [DATA_W-1:0] wdata;
    } lls_ctrl_t;

endpackage

// ----- src/lls_cell.sv -----
// One storage cell of the stack row: holds one word and moves it to a
// neighbor on push or pop, or takes a new word on a change request.
// Depends on lls_pkg.
`timescale 1ns / 1ps

module lls_cell (
    input  logic                             clk,
    input  lls_pkg::lls_ctrl_t               ctrl,
    input  logic [lls_pkg::POS_W-1:0]        cell_pos,
    input  logic signed [lls_pkg::DATA_W-1:0] above_data,
    input  logic signed [lls_pkg::DATA_W-1:0] below_data,
    output logic signed [lls_pkg::DATA_W-1:0] data
);
    import lls_pkg::*;

    logic signed [DATA_W-1:0] data_reg;

    // Cell zero is the top of the stack; a push moves every word one cell
    // deeper and a pop moves every word one cell toward the top.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            data_reg <= above_data;
        end
        else if (ctrl.pop)
        begin
            data_reg <= below_data;
        end
        else if (ctrl.change && (ctrl.change_pos == cell_pos))
        begin
            data_reg <= ctrl.wdata;
        end
    end

    assign data = data_reg;

endmodule

// ----- src/lls_chain.sv -----
// Row of DEPTH stack cells linked to their neighbors; presents the word
// held in the top cell. Depends on lls_pkg and lls_cell.
`timescale 1ns / 1ps

module lls_chain (
    input  logic                              clk,
    input  lls_pkg::lls_ctrl_t                ctrl,
    output logic signed [lls_pkg::DATA_W-1:0] top_data
);
    import lls_pkg::*;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] above    [DEPTH];
    logic signed [DATA_W-1:0] below    [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign above[i] = ctrl.wdata;
            end
            else
            begin : g_inner_above
                assign above[i] = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign below[i] = '0;
            end
            else
            begin : g_inner_below
                assign below[i] = cell_data[i+1];
            end

            lls_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .cell_pos   (POS_W'(i)),
                .above_data (above[i]),
                .below_data (below[i]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    assign top_data = cell_data[0];

endmodule

// ----- src/bounded_lifo_stack_top.sv -----
// Top level of the bounded LIFO stack: request decode, fill level, result
// registers. Depends on lls_pkg and lls_chain.
`timescale 1ns / 1ps

// Usage
// A request is a transfer on the command channel: it is taken at a rising
// clock edge where start is high and busy is low, with action, entry_index
// and write_value alongside. Busy never rises, so a request may be given in
// every cycle.
// Exactly one result follows each request. It appears on read_value,
// status, entry_count, is_empty and is_full in the cycle after the request is
// taken, marked by done for that single cycle; the receiver must take it
// then, since it cannot hold results off.
// Throughput is one request per cycle. It is set by the row of cells,
// which shifts every word by one cell on a push or a pop all together, so
// the top word is always in cell zero.
// A change request writes the cell whose position from the top matches
// fill level minus one minus entry_index; each cell compares that position
// with its own.
// Reset clears the fill level and the result strobe at once; the cell
// contents are left as they are, since only words written by a push are
// ever read.
module bounded_lifo_stack_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic [lls_pkg::IDX_W-1:0]          entry_index,
    input  logic signed [lls_pkg::DATA_W-1:0]  write_value,
    output logic                               done,
    output logic signed [lls_pkg::DATA_W-1:0]  read_value,
    output logic [1:0]                         status,
    output logic [lls_pkg::COUNT_W-1:0]        entry_count,
    output logic                               is_empty,
    output logic                               is_full
);
    import lls_pkg::*;

    logic [LVL_W-1:0]         fill_reg;
    logic [LVL_W-1:0]         fill_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic signed [DATA_W-1:0] read_value_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [COUNT_W-1:0]       entry_count_reg;
    logic                     is_empty_reg;
    logic                     is_full_reg;

    lls_ctrl_t                ctrl;
    logic signed [DATA_W-1:0] top_data;
    logic                     fire;
    logic                     is_empty_now;
    logic                     is_full_now;
    logic [CMP_W-1:0]         fill_wide;
    logic [CMP_W-1:0]         idx_wide;
    logic [CMP_W-1:0]         pos_wide;
    action_t                  act;

    // The stack finishes every request without stalling, so it is never busy.
    assign busy = 1'b0;
    assign fire = start && !busy;
    assign act  = action_t'(action);

    assign is_empty_now = (fill_reg == '0);
    assign is_full_now  = (fill_reg == LVL_W'(DEPTH));

    assign fill_wide = CMP_W'(fill_reg);
    assign idx_wide  = CMP_W'(entry_index);
    assign pos_wide  = fill_wide - CMP_W'(1) - idx_wide;

    always_comb
    begin
        ctrl            = '0;
        ctrl.wdata      = write_value;
        ctrl.change_pos = POS_W'(pos_wide);
        fill_next       = fill_reg;
        read_value_next = '0;
        status_next     = ST_OK;

        unique case (act)
            ACT_PUSH:
            begin
                if (is_full_now)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    ctrl.push = fire;
                    fill_next = fill_reg + LVL_W'(1);
                end
            end
            ACT_POP:
            begin
                if (is_empty_now)
                begin
                    status_next     = ST_EMPTY;
                    read_value_next = -32'sd1;
                end
                else
                begin
                    ctrl.pop        = fire;
                    fill_next       = fill_reg - LVL_W'(1);
                    read_value_next = top_data;
                end
            end
            ACT_PEEK:
            begin
                if (is_empty_now)
                begin
                    status_next     = ST_EMPTY;
                    read_value_next = -32'sd1;
                end
                else
                begin
                    read_value_next = top_data;
                end
            end
            ACT_CHANGE:
            begin
                if (idx_wide >= fill_wide)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    ctrl.change = fire;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    lls_chain u_chain (
        .clk      (clk),
        .ctrl     (ctrl),
        .top_data (top_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fire;
            if (fire)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Result payload is only meaningful while done is high.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_value_reg  <= read_value_next;
            status_reg      <= status_next;
            entry_count_reg <= COUNT_W'(fill_next);
            is_empty_reg    <= (fill_next == '0);
            is_full_reg     <= (fill_next == LVL_W'(DEPTH));
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for bounded_lifo_stack_top: directed and random requests
// through the start/busy command port, with every done result checked in order.
// Depends on lls_pkg and the RTL of the stack.
`timescale 1ns / 1ps

module tb;

    import lls_pkg::*;

    // One result as the stack reports it.
    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        status_t                  status;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic                     is_full;
    } stack_result_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic [1:0]               action      = ACT_PUSH;
    logic [IDX_W-1:0]         entry_index = '0;
    logic signed [DATA_W-1:0] write_value = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;

    // The testbench's own copy of the stack contents and fill level.
    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int                       shadow_level = 0;

    // Results that were predicted at request time and have not come back yet.
    stack_result_t            awaited_results [$];
    int                       error_count  = 0;

    // Percentage of cycles in which the sender holds back between requests.
    int                       sender_idle_pct = 0;

    bounded_lifo_stack_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .entry_index (entry_index),
        .write_value (write_value),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    always #5 clk = ~clk;

    // Applies one request to the shadow stack and returns the result that the
    // block must report for it. The state here moves exactly as the block's does.
    function automatic stack_result_t apply_stack_request(action_t act,
                                                          logic [IDX_W-1:0] idx,
                                                          logic signed [DATA_W-1:0] val);
        stack_result_t res;
        res.read_value = '0;
        res.status     = ST_OK;
        case (act)
            ACT_PUSH:
            begin
                // A push on a full stack stores nothing and reports overflow.
                if (shadow_level >= DEPTH)
                begin
                    res.status = ST_OVERFLOW;
                end
                else
                begin
                    shadow_words[shadow_level] = val;
                    shadow_level++;
                end
            end
            ACT_POP, ACT_PEEK:
            begin
                // Popping or peeking an empty stack reports empty with a word of all ones.
                if (shadow_level == 0)
                begin
                    res.status     = ST_EMPTY;
                    res.read_value = -1;
                end
                else
                begin
                    res.read_value = shadow_words[shadow_level - 1];
                    if (act == ACT_POP)
                    begin
                        shadow_level--;
                    end
                end
            end
            default:
            begin
                // A change only reaches positions that currently hold a word.
                if (int'(idx) >= shadow_level)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    shadow_words[idx] = val;
                end
            end
        endcase
        res.entry_count = COUNT_W'(shadow_level);
        res.is_empty    = (shadow_level == 0);
        res.is_full     = (shadow_level == DEPTH);
        return res;
    endfunction

    // Presents one request and holds it until the block takes it. The expected
    // result is worked out at the edge of the transfer. Start is left high so
    // back-to-back requests need no extra cycle; the sender drops it only when
    // it idles or drains.
    task automatic send_request(action_t act, logic [IDX_W-1:0] idx,
                                logic signed [DATA_W-1:0] val);
        start       <= 1'b1;
        action      <= act;
        entry_index <= idx;
        write_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        awaited_results.push_back(apply_stack_request(act, idx, val));
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until every predicted result has been checked.
    // It always waits for a clock edge, so the next request is driven at a later edge.
    task automatic drain_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited_results.size() != 0);
    endtask

    // Every result is taken at the edge that ends its done cycle. Outputs are
    // read at the clock edge, before the block's own updates for that edge land.
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", want.read_value, read_value);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
                    error_count++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
                    error_count++;
                end
                if (is_full !== want.is_full)
                begin
                    $error("is_full: expected %0d, got %0d", want.is_full, is_full);
                    error_count++;
                end
            end
        end
    end

    // Every access to an empty stack: both reads report empty, and no position
    // can be changed, at the bottom or at the top of the index range.
    task automatic test_empty_stack();
        send_request(ACT_POP, '0, '0);
        send_request(ACT_PEEK, '0, '0);
        send_request(ACT_CHANGE, 7'd0, 32'sd5);
        send_request(ACT_CHANGE, 7'd127, -32'sd1);
    endtask

    // The extreme words go in, get overwritten at the bottom and the top, and
    // come back out in reverse order. A change at the fill level itself and at
    // the highest index must be refused.
    task automatic test_extreme_words();
        send_request(ACT_PUSH, 7'd127, 32'sh8000_0000);
        send_request(ACT_PUSH, 7'd0, 32'sh7FFF_FFFF);
        send_request(ACT_PUSH, 7'd0, 32'sd0);
        send_request(ACT_PUSH, 7'd0, -32'sd1);
        send_request(ACT_PEEK, '0, '0);
        send_request(ACT_CHANGE, 7'd0, 32'sh5555_5555);
        send_request(ACT_CHANGE, 7'd3, 32'shAAAA_AAAA);
        send_request(ACT_CHANGE, 7'd4, 32'sd1);
        send_request(ACT_CHANGE, 7'd127, 32'sd1);
        send_request(ACT_PEEK, '0, '0);
        repeat (4)
        begin
            send_request(ACT_POP, '0, '0);
        end
        send_request(ACT_POP, '0, '0);
        send_request(ACT_PEEK, '0, '0);
    endtask

    // Random traffic in stretches with a changing push share, so the fill
    // level swings from empty to full and back: a high share drives the stack
    // into overflow, a low one down to empty reads. Once per stretch the
    // sender waits for all results before going on.
    task automatic test_random_traffic(int item_total, int idle_pct);
        int                       push_share [6] = '{97, 8, 60, 95, 40, 5};
        int                       stretch;
        int                       pick;
        action_t                  act;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        sender_idle_pct = idle_pct;
        stretch = 0;
        for (int n = 0; n < item_total; n++)
        begin
            if (n % 144 == 0)
            begin
                stretch = $urandom_range(5);
            end
            if (n % 144 == 72)
            begin
                drain_results();
            end
            if ($urandom_range(99) < push_share[stretch])
            begin
                act = ACT_PUSH;
            end
            else
            begin
                pick = $urandom_range(3);
                act  = (pick < 2) ? ACT_POP : ((pick == 2) ? ACT_PEEK : ACT_CHANGE);
            end
            // Indexes mostly hit a live position, sometimes the fill level
            // itself, and otherwise anything in the field's range.
            pick = $urandom_range(9);
            if (pick < 6 && shadow_level > 0)
            begin
                idx = IDX_W'($urandom_range(shadow_level - 1));
            end
            else if (pick == 6 && shadow_level < DEPTH)
            begin
                idx = IDX_W'(shadow_level);
            end
            else
            begin
                idx = IDX_W'($urandom_range(127));
            end
            case ($urandom_range(15))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7FFF_FFFF;
                2:       val = 32'sd0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            send_request(act, idx, val);
        end
        drain_results();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_extreme_words();
        drain_results();

        // Light sender gaps, then heavy ones, then none at all.
        test_random_traffic(430, 11);
        test_random_traffic(430, 87);
        test_random_traffic(440, 0);

        // The block answers in the cycle after a transfer; the extra wait
        // catches any stray result strobe.
        repeat (8) @(posedge clk);
        if (error_count == 0 && awaited_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
